// ===== rtl/core/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/spq_ifs.sv =====
`timescale 1ns / 1ps

interface spq_req_if #(
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 16
);
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [VALUE_WIDTH-1:0]           item_value;
    logic signed [PRIORITY_WIDTH-1:0] item_priority;

    modport source (output valid, output operation, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input operation, input item_value,
                    input item_priority, output ready);
endinterface

interface spq_rsp_if #(
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 16,
    parameter int COUNT_WIDTH    = 5
);
    logic                             valid;
    logic                             ready;
    logic [spq_pkg::STATUS_W-1:0]     status;
    logic [VALUE_WIDTH-1:0]           out_value;
    logic signed [PRIORITY_WIDTH-1:0] out_priority;
    logic [COUNT_WIDTH-1:0]           entry_count;
    logic                             is_empty;

    modport source (output valid, output status, output out_value,
                    output out_priority, output entry_count, output is_empty,
                    input ready);
    modport sink   (input valid, input status, input out_value,
                    input out_priority, input entry_count, input is_empty,
                    output ready);
endinterface

// ===== rtl/core/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell #(
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                             clk,
    input  spq_pkg::cell_ctrl_t              ctrl,
    input  logic                             occupied,
    input  logic [VALUE_WIDTH-1:0]           new_value,
    input  logic signed [PRIORITY_WIDTH-1:0] new_priority,
    input  logic                             prev_lt,
    input  logic [VALUE_WIDTH-1:0]           prev_value,
    input  logic signed [PRIORITY_WIDTH-1:0] prev_priority,
    input  logic [VALUE_WIDTH-1:0]           next_value,
    input  logic signed [PRIORITY_WIDTH-1:0] next_priority,
    output logic                             lt,
    output logic [VALUE_WIDTH-1:0]           value,
    output logic signed [PRIORITY_WIDTH-1:0] priority_q
);
    import spq_pkg::*;

    logic [VALUE_WIDTH-1:0]           value_reg;
    logic [VALUE_WIDTH-1:0]           value_next;
    logic signed [PRIORITY_WIDTH-1:0] prio_reg;
    logic signed [PRIORITY_WIDTH-1:0] prio_next;

    // new entry sorts ahead of this slot (empty slots always yield)
    assign lt = !occupied || (prio_reg < new_priority);

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.rem_en)
        begin
            value_next = next_value;
            prio_next  = next_priority;
        end
        else if (ctrl.ins_en && lt)
        begin
            if (prev_lt)
            begin
                value_next = prev_value;
                prio_next  = prev_priority;
            end
            else
            begin
                value_next = new_value;
                prio_next  = new_priority;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value      = value_reg;
    assign priority_q = prio_reg;

endmodule

// ===== rtl/core/sorted_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// the response to an accepted request word is registered and valid in the next cycle
// throughput: one word per cycle; every cell compares and shifts in the same cycle
// a new word is taken only while the response register is empty or drained that cycle
// reset: entry count and response valid clear; cell contents are not cleared
// and only slots below the entry count are ever read

module sorted_priority_queue_unit #(
    parameter int DEPTH          = 16,
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // chain wiring, one slot per cell; the boundary cells get constants
    logic [VALUE_WIDTH-1:0]           cell_value [DEPTH];
    logic signed [PRIORITY_WIDTH-1:0] cell_prio  [DEPTH];
    logic [DEPTH-1:0]                 cell_lt;
    logic [DEPTH-1:0]                 occupied;

    logic       accept;
    logic       q_full;
    logic       q_empty;
    cell_ctrl_t ctrl;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // response register
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [STATUS_W-1:0]              status_reg;
    logic [STATUS_W-1:0]              status_next;
    logic [VALUE_WIDTH-1:0]           out_value_reg;
    logic [VALUE_WIDTH-1:0]           out_value_next;
    logic signed [PRIORITY_WIDTH-1:0] out_prio_reg;
    logic signed [PRIORITY_WIDTH-1:0] out_prio_next;
    logic [CW-1:0]                    out_count_reg;
    logic                             is_empty_reg;

    // take a word whenever the response slot is free or being drained
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign q_full  = (count_reg == FULL_COUNT);
    assign q_empty = (count_reg == '0);

    // decode the word into a chain command and the response fields
    always_comb
    begin
        ctrl           = '0;
        count_next     = count_reg;
        status_next    = STATUS_DONE;
        out_value_next = '0;
        out_prio_next  = '0;
        unique case (req.operation)
            OP_INSERT:
            begin
                if (q_full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    ctrl.ins_en = accept;
                    count_next  = count_reg + CW'(1);
                end
            end
            OP_REMOVE:
            begin
                if (q_empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    // head of the chain is the highest priority entry
                    ctrl.rem_en    = accept;
                    out_value_next = cell_value[0];
                    out_prio_next  = cell_prio[0];
                    count_next     = count_reg - CW'(1);
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // slot occupancy follows from the count; no per-cell valid flags
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_occ
            localparam logic [CW-1:0] IDX = CW'(i);
            assign occupied[i] = (IDX < count_reg);
        end
    endgenerate

    // the cell chain: insert shifts toward the tail, remove toward the head
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                             p_lt;
            logic [VALUE_WIDTH-1:0]           p_value;
            logic signed [PRIORITY_WIDTH-1:0] p_prio;
            logic [VALUE_WIDTH-1:0]           n_value;
            logic signed [PRIORITY_WIDTH-1:0] n_prio;

            if (i == 0)
            begin : g_head
                // head never inherits from a neighbor on insert
                assign p_lt    = 1'b0;
                assign p_value = '0;
                assign p_prio  = '0;
            end
            else
            begin : g_mid
                assign p_lt    = cell_lt[i-1];
                assign p_value = cell_value[i-1];
                assign p_prio  = cell_prio[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                // tail slot goes empty on remove; its contents are don't care
                assign n_value = '0;
                assign n_prio  = '0;
            end
            else
            begin : g_body
                assign n_value = cell_value[i+1];
                assign n_prio  = cell_prio[i+1];
            end

            spq_cell #(
                .VALUE_WIDTH    (VALUE_WIDTH),
                .PRIORITY_WIDTH (PRIORITY_WIDTH)
            ) u_cell (
                .clk           (clk),
                .ctrl          (ctrl),
                .occupied      (occupied[i]),
                .new_value     (req.item_value),
                .new_priority  (req.item_priority),
                .prev_lt       (p_lt),
                .prev_value    (p_value),
                .prev_priority (p_prio),
                .next_value    (n_value),
                .next_priority (n_prio),
                .lt            (cell_lt[i]),
                .value         (cell_value[i]),
                .priority_q    (cell_prio[i])
            );
        end
    endgenerate

    // response valid: set on accept, cleared when taken
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // response payload, loaded with each accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            out_value_reg <= out_value_next;
            out_prio_reg  <= out_prio_next;
            out_count_reg <= count_next;
            is_empty_reg  <= (count_next == '0);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_value    = out_value_reg;
    assign rsp.out_priority = out_prio_reg;
    assign rsp.entry_count  = out_count_reg;
    assign rsp.is_empty     = is_empty_reg;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int VAL_W       = 32;
    localparam int PRI_W       = 16;
    localparam int CNT_W       = 5;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_WORDS = 1030;
    localparam int MAX_REPORTS = 10;

    // one request word waiting to be sent, with the idle gap that follows it
    typedef struct {
        logic                    op;
        logic [VAL_W-1:0]        value;
        logic signed [PRI_W-1:0] prio;
        int                      gap_after;
    } request_word_t;

    // what the queue should answer for one request word
    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic [VAL_W-1:0]        removed_value;
        logic signed [PRI_W-1:0] removed_priority;
        logic [CNT_W-1:0]        count;
        logic                    empty;
    } queue_result_t;

    logic clk;
    logic rst_n;

    spq_req_if #(.VALUE_WIDTH(VAL_W), .PRIORITY_WIDTH(PRI_W)) req_bus ();
    spq_rsp_if #(.VALUE_WIDTH(VAL_W), .PRIORITY_WIDTH(PRI_W), .COUNT_WIDTH(CNT_W)) rsp_bus ();

    sorted_priority_queue_unit #(
        .DEPTH          (QUEUE_DEPTH),
        .VALUE_WIDTH    (VAL_W),
        .PRIORITY_WIDTH (PRI_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // words still to be sent, filled up front by the stimulus block
    request_word_t pending_words[$];
    // predicted answers, oldest first
    queue_result_t awaited_results[$];

    // shadow copy of the sorted queue, head at slot 0
    logic [VAL_W-1:0]        shadow_value[QUEUE_DEPTH];
    logic signed [PRI_W-1:0] shadow_priority[QUEUE_DEPTH];
    int                      shadow_count = 0;

    int error_count  = 0;
    int cycle_count  = 0;
    int words_taken  = 0;
    int hold_left    = 0;
    int holds_done   = 0;
    int send_idle    = 0;
    int last_gap     = 0;
    int ready_stall  = 0;

    // clock, reset and known values on every block input from time zero
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.operation = OP_INSERT;
        req_bus.item_value = '0;
        req_bus.item_priority = '0;
        rsp_bus.ready = 1'b0;
        fork
            forever #1 clk = ~clk;
        join_none
        repeat (3) @(posedge clk);
        // release away from the rising edge so nothing races with it
        @(negedge clk);
        rst_n = 1'b1;
    end

    // walk the shadow queue through one request word and return its answer
    function automatic queue_result_t apply_request(logic op, logic [VAL_W-1:0] value,
                                                    logic signed [PRI_W-1:0] prio);
        queue_result_t res;
        int slot;
        res.status = STATUS_DONE;
        res.removed_value = '0;
        res.removed_priority = '0;
        if (op == OP_INSERT)
        begin
            if (shadow_count >= QUEUE_DEPTH)
                res.status = STATUS_FULL;  // dropped, queue unchanged
            else
            begin
                // new entry goes behind every entry of equal or higher priority
                slot = 0;
                while (slot < shadow_count && shadow_priority[slot] >= prio)
                    slot++;
                for (int i = shadow_count; i > slot; i--)
                begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_priority[i] = shadow_priority[i-1];
                end
                shadow_value[slot] = value;
                shadow_priority[slot] = prio;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
            res.status = STATUS_EMPTY;
        else
        begin
            // pop the head and close the gap
            res.removed_value = shadow_value[0];
            res.removed_priority = shadow_priority[0];
            for (int i = 1; i < shadow_count; i++)
            begin
                shadow_value[i-1] = shadow_value[i];
                shadow_priority[i-1] = shadow_priority[i];
            end
            shadow_count--;
        end
        res.count = CNT_W'(shadow_count);
        res.empty = (shadow_count == 0);
        return res;
    endfunction

    task automatic flag_error(string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
    endtask

    task automatic add_word(logic op, logic [VAL_W-1:0] value,
                            logic signed [PRI_W-1:0] prio, int gap_after);
        request_word_t w;
        w.op = op;
        w.value = value;
        w.prio = prio;
        w.gap_after = gap_after;
        pending_words.push_back(w);
    endtask

    // mostly back to back, sometimes a short pause, now and then a long one; never a pause when busy
    function automatic int pick_gap(bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (busy || r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // small priorities give lots of ties, which checks arrival order
    function automatic logic signed [PRI_W-1:0] pick_priority();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
        else if (r < 3)
            return PRI_W'($urandom);
        else
            return PRI_W'($signed($urandom_range(0, 6)) - 3);
    endfunction

    // stimulus: directed corners first, then random phases of varying insert bias
    initial
    begin
        int made;
        int phase_len;
        int insert_pct;
        bit busy;
        logic op;

        // remove on an empty queue
        add_word(OP_REMOVE, 32'hffff_ffff, 16'sh7fff, 0);
        // field extremes and ties, sixteen entries fill the queue
        add_word(OP_INSERT, 32'h0000_0000, 16'sh0000, 0);
        add_word(OP_INSERT, 32'hffff_ffff, 16'sh7fff, 0);
        add_word(OP_INSERT, 32'h0000_0001, 16'sh8000, 0);
        add_word(OP_INSERT, 32'ha5a5_a5a5, -16'sd1, 0);
        add_word(OP_INSERT, 32'h5a5a_5a5a, 16'sd1, 0);
        add_word(OP_INSERT, 32'h0000_0100, 16'sh0000, 0);
        add_word(OP_INSERT, 32'h0000_0101, 16'sh0000, 0);
        add_word(OP_INSERT, 32'h0000_0102, 16'sh7fff, 0);
        add_word(OP_INSERT, 32'h0000_0103, 16'sh8000, 0);
        add_word(OP_INSERT, 32'h8000_0000, 16'sh7fff, 0);
        add_word(OP_INSERT, 32'h7fff_ffff, 16'sh8000, 0);
        add_word(OP_INSERT, 32'h0000_0104, 16'sh0000, 0);
        add_word(OP_INSERT, 32'hdead_beef, 16'sh4000, 0);
        add_word(OP_INSERT, 32'hcafe_f00d, -16'sh4000, 0);
        add_word(OP_INSERT, 32'h1234_5678, 16'sh0000, 0);
        add_word(OP_INSERT, 32'h8765_4321, 16'sh7ffe, 0);
        // queue full, this one is dropped
        add_word(OP_INSERT, 32'hffff_ffff, 16'sh7fff, 0);
        // pop a few heads, including equal priority ones
        repeat (4)
            add_word(OP_REMOVE, 32'h0, 16'sh0, 0);

        made = 0;
        while (made < RANDOM_WORDS)
        begin
            phase_len = $urandom_range(8, 64);
            case ($urandom_range(0, 3))
                0: insert_pct = 15;
                1: insert_pct = 50;
                2: insert_pct = 85;
                default: insert_pct = 95;
            endcase
            // some phases run with no gaps at all
            busy = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
            begin
                op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
                add_word(op, $urandom, pick_priority(), pick_gap(busy));
                made++;
            end
        end
    end

    // request driver: holds a word until taken, then waits out its gap
    always @(posedge clk or negedge rst_n)
    begin
        request_word_t w;
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            send_idle = 0;
            last_gap = 0;
        end
        else if (!req_bus.valid || req_bus.ready)
        begin
            if (req_bus.valid)
                send_idle = last_gap;
            if (send_idle > 0)
            begin
                send_idle--;
                req_bus.valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                w = pending_words.pop_front();
                req_bus.operation <= w.op;
                req_bus.item_value <= w.value;
                req_bus.item_priority <= w.prio;
                req_bus.valid <= 1'b1;
                last_gap = w.gap_after;
            end
            else
                req_bus.valid <= 1'b0;
        end
    end

    // long receiver hold-off, twice, so the output register fills and the
    // queue has to push back on the request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if ((holds_done == 0 && words_taken >= 300) ||
                 (holds_done == 1 && words_taken >= 750))
        begin
            hold_left <= 120;
            holds_done <= holds_done + 1;
        end
    end

    // response ready: random stalls, with no new random stall started in every fourth window of the cycle count
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            ready_stall = 0;
        end
        else if (hold_left != 0)
            rsp_bus.ready <= 1'b0;
        else if (ready_stall > 0)
        begin
            ready_stall--;
            rsp_bus.ready <= 1'b0;
        end
        else if ((cycle_count / 400) % 4 == 1 || $urandom_range(0, 99) < 65)
            rsp_bus.ready <= 1'b1;
        else
        begin
            ready_stall = pick_gap(1'b0);
            rsp_bus.ready <= 1'b0;
        end
    end

    // monitor: predict on every accepted request word, check every accepted response word
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                awaited_results.push_back(apply_request(req_bus.operation,
                                                        req_bus.item_value,
                                                        req_bus.item_priority));
                words_taken <= words_taken + 1;
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (awaited_results.size() == 0)
                    flag_error("response word with no request waiting for it");
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_bus.status !== want.status ||
                        rsp_bus.out_value !== want.removed_value ||
                        rsp_bus.out_priority !== want.removed_priority ||
                        rsp_bus.entry_count !== want.count ||
                        rsp_bus.is_empty !== want.empty)
                        flag_error($sformatf({"mismatch: expected status %0d value %h ",
                            "priority %0d count %0d empty %0b, got status %0d value %h ",
                            "priority %0d count %0d empty %0b"},
                            want.status, want.removed_value, want.removed_priority,
                            want.count, want.empty, rsp_bus.status, rsp_bus.out_value,
                            rsp_bus.out_priority, rsp_bus.entry_count, rsp_bus.is_empty));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, awaited_results.size());
            $display("** sorted_priority_queue_unit: FAILED **");
            $finish;
        end
    end

    // end of run: everything sent and answered, then a short drain for stragglers
    initial
    begin
        @(posedge rst_n);
        do
            @(posedge clk);
        while (pending_words.size() != 0 || req_bus.valid || awaited_results.size() != 0);
        repeat (8) @(posedge clk);
        if (awaited_results.size() != 0)
            flag_error($sformatf("%0d responses never arrived", awaited_results.size()));
        if (error_count == 0)
            $display("** sorted_priority_queue_unit: PASSED **");
        else
            $display("** sorted_priority_queue_unit: FAILED **");
        $finish;
    end

endmodule

// ===== sorted_priority_queue_unit.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_ifs.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_unit.sv
test/testbench.sv
